>>> rtl/e2q_pkg.sv
package e2q_pkg;

  typedef logic signed [31:0] cs_t;
  typedef logic signed [33:0] ang_t;

  typedef struct packed {
    cs_t  x;
    cs_t  y;
    ang_t z;
    logic neg;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  localparam int   LANES       = 3;
  localparam int   ATAN_DEPTH  = 30;
  localparam int   FIELD_BITS  = 16;
  localparam cs_t  GAIN_Q30    = 32'sd652032874;
  localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
  localparam ang_t PI_Q30      = 34'sd3373259426;

  localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

endpackage

>>> rtl/e2q_prep.sv
module e2q_prep
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [2:0][FIELD_BITS-1:0] angle_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output lanes_t                    lanes_o
);

  logic   valid_q;
  lanes_t lanes_d, lanes_q;

  always_comb begin
    logic [31:0] raw;
    logic [31:0] sh;
    ang_t        h;
    for (int k = 0; k < LANES; k++) begin
      raw = {{(32-FIELD_BITS){1'b0}}, angle_i[k]};
      sh  = raw << (32 - ANGLE_BITS);
      h   = {{2{sh[31]}}, sh};
      lanes_d[k].x   = GAIN_Q30;
      lanes_d[k].y   = '0;
      lanes_d[k].z   = h;
      lanes_d[k].neg = 1'b0;
      // fold half angles outside a quarter turn
      if (h > HALF_PI_Q30) begin
        lanes_d[k].z   = h - PI_Q30;
        lanes_d[k].neg = 1'b1;
      end else if (h < -HALF_PI_Q30) begin
        lanes_d[k].z   = h + PI_Q30;
        lanes_d[k].neg = 1'b1;
      end
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

>>> rtl/e2q_cordic_cell.sv
module e2q_cordic_cell
  import e2q_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  lanes_t lanes_i,
  output logic   valid_o,
  input  logic   ready_i,
  output lanes_t lanes_o
);

  localparam ang_t ATAN_STEP = {2'b00, ATAN_Q30[STAGE]};

  logic   valid_q;
  lanes_t lanes_d, lanes_q;

  always_comb begin
    cs_t xs;
    cs_t ys;
    for (int k = 0; k < LANES; k++) begin
      xs = $signed(lanes_i[k].x) >>> STAGE;
      ys = $signed(lanes_i[k].y) >>> STAGE;
      lanes_d[k].neg = lanes_i[k].neg;
      if (!lanes_i[k].z[33]) begin
        lanes_d[k].x = $signed(lanes_i[k].x) - ys;
        lanes_d[k].y = $signed(lanes_i[k].y) + xs;
        lanes_d[k].z = $signed(lanes_i[k].z) - ATAN_STEP;
      end else begin
        lanes_d[k].x = $signed(lanes_i[k].x) + ys;
        lanes_d[k].y = $signed(lanes_i[k].y) - xs;
        lanes_d[k].z = $signed(lanes_i[k].z) + ATAN_STEP;
      end
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

>>> rtl/e2q_quat.sv
module e2q_quat
  import e2q_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  lanes_t                 lanes_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [FIELD_BITS-1:0]  quat_w_o,
  output logic [FIELD_BITS-1:0]  quat_x_o,
  output logic [FIELD_BITS-1:0]  quat_y_o,
  output logic [FIELD_BITS-1:0]  quat_z_o
);

  localparam int NSTG = 4;

  function automatic cs_t mul_q30(cs_t a, cs_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd536870912;
    p = p >>> 30;
    return p[31:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_q14(cs_t a, cs_t b, logic sub);
    logic signed [33:0] s;
    logic signed [17:0] r;
    if (sub) begin
      s = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    end else begin
      s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    end
    s = s + 34'sd32768;
    r = s[33:16];
    if (r > 18'sd16384) begin
      return 16'sd16384;
    end else if (r < -18'sd16384) begin
      return -16'sd16384;
    end
    return r[15:0];
  endfunction

  logic [NSTG-1:0] valid_q;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;

  cs_t cr_q, sr_q, cp_q, sp_q, cy_q, sy_q;
  cs_t pcc_q, pss_q, psc_q, pcs_q, cy1_q, sy1_q;
  cs_t wa_q, wb_q, xa_q, xb_q, ya_q, yb_q, za_q, zb_q;
  logic [FIELD_BITS-1:0] w_q, x_q, y_q, z_q;

  assign vin = {valid_q[NSTG-2:0], valid_i};

  always_comb begin
    rdy[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  // sign fix for folded half angles
  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      cr_q <= lanes_i[0].neg ? -lanes_i[0].x : lanes_i[0].x;
      sr_q <= lanes_i[0].neg ? -lanes_i[0].y : lanes_i[0].y;
      cp_q <= lanes_i[1].neg ? -lanes_i[1].x : lanes_i[1].x;
      sp_q <= lanes_i[1].neg ? -lanes_i[1].y : lanes_i[1].y;
      cy_q <= lanes_i[2].neg ? -lanes_i[2].x : lanes_i[2].x;
      sy_q <= lanes_i[2].neg ? -lanes_i[2].y : lanes_i[2].y;
    end
  end

  // roll by pitch products
  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      pcc_q <= mul_q30(cr_q, cp_q);
      pss_q <= mul_q30(sr_q, sp_q);
      psc_q <= mul_q30(sr_q, cp_q);
      pcs_q <= mul_q30(cr_q, sp_q);
      cy1_q <= cy_q;
      sy1_q <= sy_q;
    end
  end

  // triple products
  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      wa_q <= mul_q30(pcc_q, cy1_q);
      wb_q <= mul_q30(pss_q, sy1_q);
      xa_q <= mul_q30(psc_q, cy1_q);
      xb_q <= mul_q30(pcs_q, sy1_q);
      ya_q <= mul_q30(pcs_q, cy1_q);
      yb_q <= mul_q30(psc_q, sy1_q);
      za_q <= mul_q30(pcc_q, sy1_q);
      zb_q <= mul_q30(pss_q, cy1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vin[3]) begin
      w_q <= to_q14(wa_q, wb_q, 1'b0);
      x_q <= to_q14(xa_q, xb_q, 1'b1);
      y_q <= to_q14(ya_q, yb_q, 1'b0);
      z_q <= to_q14(za_q, zb_q, 1'b1);
    end
  end

  assign ready_o  = rdy[0];
  assign valid_o  = valid_q[NSTG-1];
  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

>>> rtl/euler_to_quaternion.sv
// channel  dir  tdata bits  fields, lowest bit up
// s_axis   in   48          roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
// m_axis   out  64          quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// one transaction per cycle sustained while m_axis_tready stays high; the registers in order are
// fold register, one register per cordic cell, sign fix, two multiplier ranks, output
// rst_ni clears only the valid bits of the pipeline, asynchronously
// every stage holds while the next is full and stalled, so bubbles close up
// and s_axis_tready drops only when the whole pipeline is full behind m_axis
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

  lanes_t                      chain_data [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]      chain_valid;
  logic [CORDIC_STAGES:0]      chain_ready;
  logic [2:0][FIELD_BITS-1:0]  angle;

  assign angle[0] = s_axis_tdata[15:0];
  assign angle[1] = s_axis_tdata[31:16];
  assign angle[2] = s_axis_tdata[47:32];

  e2q_prep #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .angle_i(angle),
    .valid_o(chain_valid[0]),
    .ready_i(chain_ready[0]),
    .lanes_o(chain_data[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    e2q_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[k]),
      .ready_o(chain_ready[k]),
      .lanes_i(chain_data[k]),
      .valid_o(chain_valid[k+1]),
      .ready_i(chain_ready[k+1]),
      .lanes_o(chain_data[k+1])
    );
  end

  e2q_quat u_quat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .ready_o (chain_ready[CORDIC_STAGES]),
    .lanes_i (chain_data[CORDIC_STAGES]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .quat_w_o(m_axis_tdata[15:0]),
    .quat_x_o(m_axis_tdata[31:16]),
    .quat_y_o(m_axis_tdata[47:32]),
    .quat_z_o(m_axis_tdata[63:48])
  );

endmodule
